// ===== rtl/sop_pkg.sv =====
// Shared constants and the arctangent table for the sine-of-polynomial block.
`timescale 1ns / 1ps
package sop_pkg;

   // Angle width at 30 fractional bits and rotation datapath width
   localparam int ZW      = 35;
   localparam int XW      = 34;
   localparam int MAX_ROT = 32;

   localparam logic signed [ZW-1:0] TWO_PI_Q30  = 35'sd6746518852;
   localparam logic signed [ZW-1:0] PI_Q30      = 35'sd3373259426;
   localparam logic signed [ZW-1:0] HALF_PI_Q30 = 35'sd1686629713;
   localparam logic signed [ZW-1:0] WRAP_Q30    = TWO_PI_Q30 - HALF_PI_Q30;
   localparam logic signed [XW-1:0] GAIN_Q30    = 34'sd652032875;

   // Look up atan(2^-i) at 30 fractional bits
   function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] idx);
      logic signed [ZW-1:0] a;
      case (idx)
         5'd0:  a = 35'sd843314857;
         5'd1:  a = 35'sd497837830;
         5'd2:  a = 35'sd263043837;
         5'd3:  a = 35'sd133525159;
         5'd4:  a = 35'sd67021687;
         5'd5:  a = 35'sd33543516;
         5'd6:  a = 35'sd16775851;
         5'd7:  a = 35'sd8388437;
         5'd8:  a = 35'sd4194283;
         5'd9:  a = 35'sd2097149;
         5'd10: a = 35'sd1048576;
         5'd11: a = 35'sd524288;
         5'd12: a = 35'sd262144;
         5'd13: a = 35'sd131072;
         5'd14: a = 35'sd65536;
         5'd15: a = 35'sd32768;
         5'd16: a = 35'sd16384;
         5'd17: a = 35'sd8192;
         5'd18: a = 35'sd4096;
         5'd19: a = 35'sd2048;
         5'd20: a = 35'sd1024;
         5'd21: a = 35'sd512;
         5'd22: a = 35'sd256;
         5'd23: a = 35'sd128;
         5'd24: a = 35'sd64;
         5'd25: a = 35'sd32;
         5'd26: a = 35'sd16;
         5'd27: a = 35'sd8;
         5'd28: a = 35'sd4;
         5'd29: a = 35'sd2;
         5'd30: a = 35'sd1;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

// ===== rtl/sop_if.sv =====
// Request and response channel interfaces of the sine-of-polynomial block.
`timescale 1ns / 1ps
interface sop_req_if #(parameter int DW = 32);
   logic                 valid;
   logic                 ready;
   logic signed [DW-1:0] coeff_zero;
   logic signed [DW-1:0] coeff_one;
   logic signed [DW-1:0] coeff_two;
   logic signed [DW-1:0] coeff_three;

   modport source(output valid, coeff_zero, coeff_one, coeff_two, coeff_three, input ready);
   modport sink(input valid, coeff_zero, coeff_one, coeff_two, coeff_three, output ready);
endinterface

interface sop_rsp_if #(parameter int DW = 32);
   logic                 valid;
   logic                 ready;
   logic signed [DW-1:0] sine_zero;
   logic signed [DW-1:0] sine_one;
   logic signed [DW-1:0] sine_two;
   logic signed [DW-1:0] sine_three;

   modport source(output valid, sine_zero, sine_one, sine_two, sine_three, input ready);
   modport sink(input valid, sine_zero, sine_one, sine_two, sine_three, output ready);
endinterface

// ===== rtl/sop_mod_cell.sv =====
// One restoring step of the modulo-2*pi reduction.
`timescale 1ns / 1ps
module sop_mod_cell #(
   parameter int             DW   = 32,
   parameter logic [DW-1:0]  STEP = '0
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            valid_i,
   output logic            ready_o,
   input  logic [DW-1:0]   rem_i,
   input  logic            neg_i,
   input  logic [3*DW-1:0] carry_i,
   output logic            valid_o,
   input  logic            ready_i,
   output logic [DW-1:0]   rem_o,
   output logic            neg_o,
   output logic [3*DW-1:0] carry_o
);

   logic            valid_ff, valid_in;
   logic [DW-1:0]   rem_ff, rem_in;
   logic            neg_ff;
   logic [3*DW-1:0] carry_ff;

   // Advance when empty or when the neighbor takes the request
   assign ready_o  = !valid_ff || ready_i;
   assign valid_in = ready_o ? valid_i : valid_ff;

   // Subtract the shifted period where it fits
   assign rem_in = (rem_i >= STEP) ? rem_i - STEP : rem_i;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_o && valid_i) begin
         rem_ff   <= rem_in;
         neg_ff   <= neg_i;
         carry_ff <= carry_i;
      end
   end

   assign valid_o = valid_ff;
   assign rem_o   = rem_ff;
   assign neg_o   = neg_ff;
   assign carry_o = carry_ff;

endmodule

// ===== rtl/sop_fold.sv =====
// Signed remainder fix-up and quadrant fold of the reduced angle.
`timescale 1ns / 1ps
module sop_fold
   import sop_pkg::*;
#(
   parameter int            DW        = 32,
   parameter int            FRAC_BITS = 16,
   parameter int            PW        = 17,
   parameter logic [PW-1:0] PERIOD    = '0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 valid_i,
   output logic                 ready_o,
   input  logic [DW-1:0]        rem_i,
   input  logic                 neg_i,
   input  logic [3*DW-1:0]      carry_i,
   output logic                 valid_o,
   input  logic                 ready_i,
   output logic signed [ZW-1:0] z_o,
   output logic                 flip_o,
   output logic [3*DW-1:0]      carry_o
);

   localparam int K = 30 - FRAC_BITS;

   logic                 va_ff, va_in, vb_ff, vb_in, ready_b;
   logic [PW-1:0]        m, r;
   logic signed [ZW-1:0] za_ff, za_in, zb_ff, zb_in;
   logic                 flip_in, flip_ff;
   logic [3*DW-1:0]      ca_ff, cb_ff;

   assign ready_b = !vb_ff || ready_i;
   assign ready_o = !va_ff || ready_b;
   assign va_in   = ready_o ? valid_i : va_ff;
   assign vb_in   = ready_b ? va_ff : vb_ff;

   // Turn the magnitude remainder into a floor remainder, move to Q30
   assign m     = rem_i[PW-1:0];
   assign r     = (neg_i && (m != '0)) ? PERIOD - m : m;
   assign za_in = signed'(ZW'(r) << K);

   // Fold into [-pi/2, pi/2], flipping the cosine around +-pi
   always_comb begin
      if (za_ff <= HALF_PI_Q30) begin
         zb_in   = za_ff;
         flip_in = 1'b0;
      end else if (za_ff < WRAP_Q30) begin
         zb_in   = PI_Q30 - za_ff;
         flip_in = 1'b1;
      end else begin
         zb_in   = za_ff - TWO_PI_Q30;
         flip_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         va_ff <= va_in;
         vb_ff <= vb_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_o && valid_i) begin
         za_ff <= za_in;
         ca_ff <= carry_i;
      end
      if (ready_b && va_ff) begin
         zb_ff   <= zb_in;
         flip_ff <= flip_in;
         cb_ff   <= ca_ff;
      end
   end

   assign valid_o = vb_ff;
   assign z_o     = zb_ff;
   assign flip_o  = flip_ff;
   assign carry_o = cb_ff;

   // Folded angle stays within a quarter turn of zero
   a_fold_range: assert property (@(posedge clock) disable iff (reset)
      vb_ff |-> (zb_ff >= -HALF_PI_Q30) && (zb_ff <= HALF_PI_Q30))
      else $error("folded angle out of range");

endmodule

// ===== rtl/sop_rot_cell.sv =====
// One CORDIC rotation cell at a fixed shift.
`timescale 1ns / 1ps
module sop_rot_cell
   import sop_pkg::*;
#(
   parameter int DW  = 32,
   parameter int IDX = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 valid_i,
   output logic                 ready_o,
   input  logic signed [XW-1:0] x_i,
   input  logic signed [XW-1:0] y_i,
   input  logic signed [ZW-1:0] z_i,
   input  logic                 flip_i,
   input  logic [3*DW-1:0]      carry_i,
   output logic                 valid_o,
   input  logic                 ready_i,
   output logic signed [XW-1:0] x_o,
   output logic signed [XW-1:0] y_o,
   output logic signed [ZW-1:0] z_o,
   output logic                 flip_o,
   output logic [3*DW-1:0]      carry_o
);

   localparam logic signed [ZW-1:0] ANGLE = atan_q30(5'(IDX));

   logic                 valid_ff, valid_in;
   logic signed [XW-1:0] x_ff, x_in, y_ff, y_in, dx, dy;
   logic signed [ZW-1:0] z_ff, z_in;
   logic                 flip_ff;
   logic [3*DW-1:0]      carry_ff;

   assign ready_o  = !valid_ff || ready_i;
   assign valid_in = ready_o ? valid_i : valid_ff;

   // Rotate toward zero residual angle
   assign dx = y_i >>> IDX;
   assign dy = x_i >>> IDX;
   always_comb begin
      if (z_i >= 0) begin
         x_in = x_i - dx;
         y_in = y_i + dy;
         z_in = z_i - ANGLE;
      end else begin
         x_in = x_i + dx;
         y_in = y_i - dy;
         z_in = z_i + ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_o && valid_i) begin
         x_ff     <= x_in;
         y_ff     <= y_in;
         z_ff     <= z_in;
         flip_ff  <= flip_i;
         carry_ff <= carry_i;
      end
   end

   assign valid_o = valid_ff;
   assign x_o     = x_ff;
   assign y_o     = y_ff;
   assign z_o     = z_ff;
   assign flip_o  = flip_ff;
   assign carry_o = carry_ff;

endmodule

// ===== rtl/sop_post.sv =====
// Sine/cosine rounding and the Taylor coefficient products, pipelined.
`timescale 1ns / 1ps
module sop_post
   import sop_pkg::*;
#(
   parameter int DW        = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 valid_i,
   output logic                 ready_o,
   input  logic signed [XW-1:0] x_i,
   input  logic signed [XW-1:0] y_i,
   input  logic                 flip_i,
   input  logic [3*DW-1:0]      carry_i,
   output logic                 valid_o,
   input  logic                 ready_i,
   output logic signed [DW-1:0] sine_zero,
   output logic signed [DW-1:0] sine_one,
   output logic signed [DW-1:0] sine_two,
   output logic signed [DW-1:0] sine_three
);

   localparam int NS = 11;
   localparam int K  = 30 - FRAC_BITS;
   localparam int CW = (DW > XW + 1) ? DW : XW + 1;

   localparam logic signed [DW-1:0]   MAXV    = {1'b0, {(DW-1){1'b1}}};
   localparam logic signed [DW-1:0]   MINV    = {1'b1, {(DW-1){1'b0}}};
   localparam logic [2*DW-1:0]        LIM_POS = (2*DW)'({(DW-1){1'b1}});
   localparam logic [2*DW-1:0]        LIM_NEG = LIM_POS + 1'b1;
   localparam logic [2*DW-1:0]        RND     = (2*DW)'(1) << (FRAC_BITS - 1);
   localparam logic signed [XW:0]     RND_Q30 = (K == 0) ? '0 : (XW+1)'(1) << (K - 1);
   localparam logic [DW+3:0]          SIX_NUM = {1'b1, {(DW+3){1'b0}}};
   localparam logic [DW+3:0]          SIX_DIV = (SIX_NUM + 5) / 6;
   localparam logic [DW:0]            SIX_RECIP = SIX_DIV[DW:0];

   typedef struct packed {
      logic signed [DW-1:0]   s;
      logic signed [DW-1:0]   c;
      logic signed [DW-1:0]   u1;
      logic signed [DW-1:0]   u2;
      logic signed [DW-1:0]   u3;
      logic signed [DW-1:0]   y1;
      logic signed [DW-1:0]   y2;
      logic signed [DW-1:0]   y3;
      logic signed [DW-1:0]   cu2;
      logic signed [DW-1:0]   cu3;
      logic signed [DW-1:0]   sq;
      logic signed [DW-1:0]   p12;
      logic signed [DW-1:0]   sp12;
      logic signed [DW-1:0]   sh;
      logic signed [DW-1:0]   cube;
      logic signed [DW-1:0]   six;
      logic signed [DW-1:0]   cs6;
      logic signed [DW-1:0]   tsum;
      logic signed [2*DW-1:0] w_a;
      logic signed [2*DW-1:0] w_b;
      logic signed [2*DW-1:0] w_c;
      logic signed [2*DW-1:0] w_d;
      logic signed [2*DW-1:0] w_e;
      logic [2*DW:0]          w_six;
      logic                   neg;
   } post_type;

   // Round a full product to Q format, ties away from zero, and saturate
   function automatic logic signed [DW-1:0] rnd_sat(input logic signed [2*DW-1:0] p);
      logic            neg;
      logic [2*DW-1:0] mag;
      logic [2*DW-1:0] rounded;
      logic [2*DW-1:0] lim;
      neg     = p[2*DW-1];
      mag     = neg ? -p : p;
      rounded = (mag + RND) >> FRAC_BITS;
      lim     = neg ? LIM_NEG : LIM_POS;
      if (rounded > lim) begin
         rounded = lim;
      end
      return neg ? -rounded[DW-1:0] : rounded[DW-1:0];
   endfunction

   function automatic logic signed [DW-1:0] sat_add(input logic signed [DW-1:0] a,
                                                   input logic signed [DW-1:0] b);
      logic signed [DW:0] sum;
      sum = a + b;
      if (sum[DW] != sum[DW-1]) begin
         return sum[DW] ? MINV : MAXV;
      end
      return sum[DW-1:0];
   endfunction

   function automatic logic signed [DW-1:0] sat_neg(input logic signed [DW-1:0] a);
      return (a == MINV) ? MAXV : -a;
   endfunction

   // Q30 to Q format, ties toward plus infinity, then clamp
   function automatic logic signed [DW-1:0] to_q(input logic signed [XW-1:0] v);
      logic signed [XW:0]   r;
      logic signed [CW-1:0] e;
      r = v + RND_Q30;
      r = r >>> K;
      e = CW'(r);
      if (e > CW'(MAXV)) begin
         e = CW'(MAXV);
      end else if (e < CW'(MINV)) begin
         e = CW'(MINV);
      end
      return e[DW-1:0];
   endfunction

   post_type             st_ff [NS];
   post_type             st_in [NS];
   logic [NS-1:0]        v_ff, v_in;
   logic [NS:0]          en;
   logic signed [XW-1:0] xf;
   logic [DW-1:0]        cmag;

   // Per-stage advance: a stage moves when empty or when its successor moves
   always_comb begin
      en[NS] = ready_i;
      for (int k = NS - 1; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end
   assign ready_o = en[0];
   assign v_in    = {v_ff[NS-2:0], valid_i};

   always_comb begin
      st_in[0] = '0;
      for (int k = 1; k < NS; k++) begin
         st_in[k] = st_ff[k-1];
      end

      // Sine and cosine in Q format, pass the coefficients
      xf          = flip_i ? -x_i : x_i;
      st_in[0].s  = to_q(y_i);
      st_in[0].c  = to_q(xf);
      st_in[0].u1 = carry_i[DW-1:0];
      st_in[0].u2 = carry_i[2*DW-1:DW];
      st_in[0].u3 = carry_i[3*DW-1:2*DW];

      // First products
      st_in[1].w_a = st_ff[0].u1 * st_ff[0].u1;
      st_in[1].w_b = st_ff[0].u1 * st_ff[0].u2;
      st_in[1].w_c = st_ff[0].c * st_ff[0].u1;
      st_in[1].w_d = st_ff[0].c * st_ff[0].u2;
      st_in[1].w_e = st_ff[0].c * st_ff[0].u3;

      st_in[2].sq  = rnd_sat(st_ff[1].w_a);
      st_in[2].p12 = rnd_sat(st_ff[1].w_b);
      st_in[2].y1  = rnd_sat(st_ff[1].w_c);
      st_in[2].cu2 = rnd_sat(st_ff[1].w_d);
      st_in[2].cu3 = rnd_sat(st_ff[1].w_e);

      // Cube, sine times u1*u2, sine times half square
      st_in[3].w_a = st_ff[2].sq * st_ff[2].u1;
      st_in[3].w_b = st_ff[2].s * st_ff[2].p12;
      st_in[3].w_c = st_ff[2].s * (st_ff[2].sq >>> 1);

      st_in[4].cube = rnd_sat(st_ff[3].w_a);
      st_in[4].sp12 = rnd_sat(st_ff[3].w_b);
      st_in[4].sh   = rnd_sat(st_ff[3].w_c);

      // Divide the cube magnitude by six through the reciprocal
      cmag           = st_ff[4].cube[DW-1] ? -st_ff[4].cube : st_ff[4].cube;
      st_in[5].neg   = st_ff[4].cube[DW-1];
      st_in[5].w_six = cmag * SIX_RECIP;
      st_in[5].y2    = sat_add(sat_neg(st_ff[4].sh), st_ff[4].cu2);

      st_in[6].six = st_ff[5].neg ? -(DW'(st_ff[5].w_six >> (DW + 3)))
                                  : DW'(st_ff[5].w_six >> (DW + 3));

      st_in[7].w_a = st_ff[6].c * st_ff[6].six;

      st_in[8].cs6 = rnd_sat(st_ff[7].w_a);

      st_in[9].tsum = sat_add(sat_neg(st_ff[8].cs6), sat_neg(st_ff[8].sp12));

      st_in[10].y3 = sat_add(st_ff[9].tsum, st_ff[9].cu3);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k < NS; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NS; k++) begin
         if (en[k]) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   assign valid_o    = v_ff[NS-1];
   assign sine_zero  = st_ff[NS-1].s;
   assign sine_one   = st_ff[NS-1].y1;
   assign sine_two   = st_ff[NS-1].y2;
   assign sine_three = st_ff[NS-1].y3;

   // Backpressure reaches the input only when every stage is occupied
   a_full_when_blocked: assert property (@(posedge clock) disable iff (reset)
      !ready_o |-> (&v_ff))
      else $error("input blocked with a bubble in the pipeline");

   // A stalled result stays in the output stage
   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      v_ff[NS-1] && !ready_i |=> v_ff[NS-1])
      else $error("stalled result dropped");

endmodule

// ===== rtl/sine_of_polynomial_taylor.sv =====
// Top level: Taylor coefficients of sin(u(t)) for a third-order input polynomial.
//
// Usage: the request channel carries u0..u3 (signed Q format); the response
// channel returns sin u0 and the next three Taylor coefficients of sin(u(t)),
// all saturated to DATA_WIDTH bits. Both channels use valid/ready; a request
// or response moves at a clock edge where both are high.
// Datapath: modulo-reduction cells (w = bit width of 2*pi in Q format,
// 19 at the defaults), then the fold stages, the CORDIC rotation cells and
// the product/rounding stages, in that order.
// Throughput: one request per cycle; every stage is a chain cell with its own
// valid bit, so the block keeps taking requests while bubbles remain inside.
// When the receiver stalls, the results pile up stage by stage; ready on the
// request side drops only once every stage holds a request.
// Reset (synchronous, active high) clears all valid bits; data registers are
// not reset. The block holds no state between requests.
`timescale 1ns / 1ps
module sine_of_polynomial_taylor
   import sop_pkg::*;
#(
   parameter int DATA_WIDTH    = 32,
   parameter int FRAC_BITS     = 16,
   parameter int CORDIC_STAGES = 18
) (
   input logic        clock,
   input logic        reset,
   sop_req_if.sink    req_ch,
   sop_rsp_if.source  rsp_ch
);

   localparam int DW = DATA_WIDTH;
   localparam int K  = 30 - FRAC_BITS;
   localparam logic [63:0] PERIOD = (K == 0) ? 64'(TWO_PI_Q30)
                                   : (64'(TWO_PI_Q30) + (64'd1 << (K - 1))) >> K;
   localparam int PW   = $clog2(PERIOD + 1);
   localparam int NMOD = DW - PW + 1;
   localparam int NROT = (CORDIC_STAGES > MAX_ROT) ? MAX_ROT : CORDIC_STAGES;

   logic                 mod_valid [NMOD+1];
   logic                 mod_ready [NMOD+1];
   logic [DW-1:0]        mod_rem   [NMOD+1];
   logic                 mod_neg   [NMOD+1];
   logic [3*DW-1:0]      mod_carry [NMOD+1];

   logic                 rot_valid [NROT+1];
   logic                 rot_ready [NROT+1];
   logic signed [XW-1:0] rot_x     [NROT+1];
   logic signed [XW-1:0] rot_y     [NROT+1];
   logic signed [ZW-1:0] rot_z     [NROT+1];
   logic                 rot_flip  [NROT+1];
   logic [3*DW-1:0]      rot_carry [NROT+1];

   // Feed the reduction chain with the magnitude of u0
   assign mod_valid[0] = req_ch.valid;
   assign req_ch.ready = mod_ready[0];
   assign mod_neg[0]   = req_ch.coeff_zero[DW-1];
   assign mod_rem[0]   = req_ch.coeff_zero[DW-1] ? -req_ch.coeff_zero : req_ch.coeff_zero;
   assign mod_carry[0] = {req_ch.coeff_three, req_ch.coeff_two, req_ch.coeff_one};

   for (genvar k = 0; k < NMOD; k++) begin : g_mod
      sop_mod_cell #(
         .DW   (DW),
         .STEP (DW'(PERIOD << (NMOD - 1 - k)))
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .valid_i (mod_valid[k]),
         .ready_o (mod_ready[k]),
         .rem_i   (mod_rem[k]),
         .neg_i   (mod_neg[k]),
         .carry_i (mod_carry[k]),
         .valid_o (mod_valid[k+1]),
         .ready_i (mod_ready[k+1]),
         .rem_o   (mod_rem[k+1]),
         .neg_o   (mod_neg[k+1]),
         .carry_o (mod_carry[k+1])
      );
   end

   sop_fold #(
      .DW        (DW),
      .FRAC_BITS (FRAC_BITS),
      .PW        (PW),
      .PERIOD    (PW'(PERIOD))
   ) u_fold (
      .clock   (clock),
      .reset   (reset),
      .valid_i (mod_valid[NMOD]),
      .ready_o (mod_ready[NMOD]),
      .rem_i   (mod_rem[NMOD]),
      .neg_i   (mod_neg[NMOD]),
      .carry_i (mod_carry[NMOD]),
      .valid_o (rot_valid[0]),
      .ready_i (rot_ready[0]),
      .z_o     (rot_z[0]),
      .flip_o  (rot_flip[0]),
      .carry_o (rot_carry[0])
   );

   // Start each rotation from the gain-compensated unit vector
   assign rot_x[0] = GAIN_Q30;
   assign rot_y[0] = '0;

   for (genvar k = 0; k < NROT; k++) begin : g_rot
      sop_rot_cell #(
         .DW  (DW),
         .IDX (k)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .valid_i (rot_valid[k]),
         .ready_o (rot_ready[k]),
         .x_i     (rot_x[k]),
         .y_i     (rot_y[k]),
         .z_i     (rot_z[k]),
         .flip_i  (rot_flip[k]),
         .carry_i (rot_carry[k]),
         .valid_o (rot_valid[k+1]),
         .ready_i (rot_ready[k+1]),
         .x_o     (rot_x[k+1]),
         .y_o     (rot_y[k+1]),
         .z_o     (rot_z[k+1]),
         .flip_o  (rot_flip[k+1]),
         .carry_o (rot_carry[k+1])
      );
   end

   sop_post #(
      .DW        (DW),
      .FRAC_BITS (FRAC_BITS)
   ) u_post (
      .clock      (clock),
      .reset      (reset),
      .valid_i    (rot_valid[NROT]),
      .ready_o    (rot_ready[NROT]),
      .x_i        (rot_x[NROT]),
      .y_i        (rot_y[NROT]),
      .flip_i     (rot_flip[NROT]),
      .carry_i    (rot_carry[NROT]),
      .valid_o    (rsp_ch.valid),
      .ready_i    (rsp_ch.ready),
      .sine_zero  (rsp_ch.sine_zero),
      .sine_one   (rsp_ch.sine_one),
      .sine_two   (rsp_ch.sine_two),
      .sine_three (rsp_ch.sine_three)
   );

endmodule

// ===== dv/tb_sine_of_polynomial_taylor.sv =====
// Testbench for the sine-of-polynomial Taylor block: predicts each response and checks it.
`timescale 1ns / 1ps
module tb_sine_of_polynomial_taylor;
   import sop_pkg::*;

   localparam int DW = 32;
   localparam int FB = 16;
   localparam int STAGES = 18;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam logic signed [63:0] MAXV = 64'sd2147483647;
   localparam logic signed [63:0] MINV = -64'sd2147483648;

   typedef struct {
      logic signed [DW-1:0] s0;
      logic signed [DW-1:0] s1;
      logic signed [DW-1:0] s2;
      logic signed [DW-1:0] s3;
   } sine_coeffs_type;

   logic clock;
   logic reset;
   int   error_count;
   int   idle_cycles;
   bit   stall_enable;
   bit   long_stalls;
   sine_coeffs_type expected_coeffs[$];

   sop_req_if #(.DW(DW)) req_ch();
   sop_rsp_if #(.DW(DW)) rsp_ch();

   sine_of_polynomial_taylor #(
      .DATA_WIDTH(DW), .FRAC_BITS(FB), .CORDIC_STAGES(STAGES)
   ) dut (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source)
   );

   // arctangent of 2^-i at 30 fractional bits
   function automatic logic signed [63:0] rot_angle(int i);
      case (i)
         0: return 64'sd843314857;  1: return 64'sd497837830;
         2: return 64'sd263043837;  3: return 64'sd133525159;
         4: return 64'sd67021687;   5: return 64'sd33543516;
         6: return 64'sd16775851;   7: return 64'sd8388437;
         8: return 64'sd4194283;    9: return 64'sd2097149;
         default: return (i < 31) ? (64'sd1 <<< (30 - i)) : 64'sd0;
      endcase
   endfunction

   function automatic logic signed [63:0] clamp_q(logic signed [127:0] v);
      if (v > MAXV) return MAXV;
      if (v < MINV) return MINV;
      return v[63:0];
   endfunction

   // product rounded half away from zero, then saturated
   function automatic logic signed [63:0] mul_round(logic signed [63:0] a,
                                                    logic signed [63:0] b);
      logic signed [127:0] p;
      logic        [127:0] m;
      logic signed [127:0] r;
      p = 128'(a) * 128'(b);
      m = (p < 0) ? -p : p;
      m = (m + (128'd1 << (FB - 1))) >> FB;
      r = (p < 0) ? -$signed(m) : $signed(m);
      return clamp_q(r);
   endfunction

   function automatic logic signed [63:0] add_sat(logic signed [63:0] a,
                                                  logic signed [63:0] b);
      return clamp_q(128'(a) + 128'(b));
   endfunction

   // negation saturated to the field range
   function automatic logic signed [63:0] neg_sat(logic signed [63:0] a);
      if (a < -MAXV) return MAXV;
      return -a;
   endfunction

   function automatic logic signed [63:0] q30_round(logic signed [63:0] v);
      return clamp_q(128'((v + (64'sd1 <<< (29 - FB))) >>> (30 - FB)));
   endfunction

   // compute the four Taylor coefficients of sin(u(t))
   function automatic sine_coeffs_type sine_taylor(logic signed [DW-1:0] u0,
         logic signed [DW-1:0] u1, logic signed [DW-1:0] u2, logic signed [DW-1:0] u3);
      sine_coeffs_type res;
      logic signed [63:0] period, r, x, y, z, dx, dy, s, c, a1, sq, t;
      bit flip;
      period = (64'sd6746518852 + (64'sd1 <<< (29 - FB))) >>> (30 - FB);
      r = 64'(u0) % period;
      if (r < 0) r += period;
      z = r <<< (30 - FB);
      if (z > 64'sd3373259426) z -= 64'sd6746518852;
      flip = 0;
      if (z > 64'sd1686629713) begin
         z = 64'sd3373259426 - z;
         flip = 1;
      end else if (z < -64'sd1686629713) begin
         z = -64'sd3373259426 - z;
         flip = 1;
      end
      x = 64'sd652032875;
      y = 0;
      for (int i = 0; i < ((STAGES > 32) ? 32 : STAGES); i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= rot_angle(i);
         end else begin
            x += dx; y -= dy; z += rot_angle(i);
         end
      end
      if (flip) x = -x;
      s = q30_round(y);
      c = q30_round(x);
      a1 = 64'(u1);
      sq = mul_round(a1, a1);
      res.s0 = s[DW-1:0];
      t = mul_round(c, a1);
      res.s1 = t[DW-1:0];
      t = add_sat(neg_sat(mul_round(s, sq >>> 1)), mul_round(c, 64'(u2)));
      res.s2 = t[DW-1:0];
      t = mul_round(sq, a1) / 6;
      t = add_sat(neg_sat(mul_round(c, t)), neg_sat(mul_round(s, mul_round(a1, 64'(u2)))));
      t = add_sat(t, mul_round(c, 64'(u3)));
      res.s3 = t[DW-1:0];
      return res;
   endfunction

   function automatic int gap_len();
      if (!stall_enable) return 0;
      if ($urandom_range(0, 2) != 0) return 0;
      if (long_stalls && $urandom_range(0, 19) == 0) return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   task automatic report_mismatch(string what, logic [DW-1:0] got, logic [DW-1:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      error_count++;
   endtask

   // clock
   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // send one request and record its prediction; valid stays high after it
   task automatic send_request(logic [DW-1:0] u0, logic [DW-1:0] u1,
                               logic [DW-1:0] u2, logic [DW-1:0] u3);
      int g;
      g = gap_len();
      repeat (g) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.coeff_zero  <= u0;
      req_ch.coeff_one   <= u1;
      req_ch.coeff_two   <= u2;
      req_ch.coeff_three <= u3;
      do @(posedge clock); while (!req_ch.ready);
      expected_coeffs.push_back(sine_taylor(u0, u1, u2, u3));
   endtask

   // receiver stalls
   always @(posedge clock) begin
      if (reset) rsp_ch.ready <= 1'b0;
      else if (!stall_enable) rsp_ch.ready <= 1'b1;
      else if (long_stalls && $urandom_range(0, 99) == 0) rsp_ch.ready <= 1'b0;
      else rsp_ch.ready <= ($urandom_range(0, 3) != 0);
   end

   // check each response against the oldest prediction
   always @(posedge clock) begin
      sine_coeffs_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_coeffs.size() == 0) begin
            $display("unexpected response");
            error_count++;
         end else begin
            want = expected_coeffs.pop_front();
            if (rsp_ch.sine_zero !== want.s0) report_mismatch("sine_zero", rsp_ch.sine_zero, want.s0);
            if (rsp_ch.sine_one !== want.s1) report_mismatch("sine_one", rsp_ch.sine_one, want.s1);
            if (rsp_ch.sine_two !== want.s2) report_mismatch("sine_two", rsp_ch.sine_two, want.s2);
            if (rsp_ch.sine_three !== want.s3)
               report_mismatch("sine_three", rsp_ch.sine_three, want.s3);
         end
      end
   end

   // watchdog on handshake activity
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // drop valid and hold until every response has come
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (expected_coeffs.size() != 0) @(posedge clock);
   endtask

   function automatic logic [DW-1:0] rand_coeff();
      case ($urandom_range(0, 5))
         0: return 32'h7FFFFFFF;
         1: return 32'h80000000;
         2: return $urandom_range(0, 2) == 0 ? 32'h0 : $urandom_range(0, 7) << 14;
         3: return $signed($urandom_range(0, 8 << 16)) - (4 << 16);
         default: return $urandom();
      endcase
   endfunction

   // extremes and the fold regions of the angle
   task automatic test_directed();
      logic [DW-1:0] ext[4];
      ext[0] = 32'h7FFFFFFF; ext[1] = 32'h80000000; ext[2] = 32'h0; ext[3] = 32'hFFFFFFFF;
      for (int i = 0; i < 4; i++) send_request(ext[i], ext[i], ext[i], ext[i]);
      send_request(32'h0, 32'h00010000, 32'h00010000, 32'h00010000);
      send_request(32'h0001921F, 32'h00020000, 32'h0, 32'h0);   // pi/2
      send_request(32'h0003243F, 32'h00010000, 32'h00010000, 32'h0); // pi
      send_request(32'h00032440, 32'hFFFF0000, 32'h0, 32'h00010000);
      send_request(32'h0004B65F, 32'h00030000, 32'h00020000, 32'h0); // 3pi/2
      send_request(32'h0006487F, 32'h0, 32'h0, 32'h0);          // about 2pi
      send_request(32'h00064880, 32'h0, 32'h0, 32'h0);
      send_request(32'hFFFE6DE1, 32'h00010000, 32'h00010000, 32'h00010000); // -pi/2
      send_request(32'hFFFCDBC1, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF); // -pi
      send_request(32'h00010000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
      send_request(32'h00010000, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
      send_request(32'h00008000, 32'h00008000, 32'h00000001, 32'hFFFFFFFF);
      send_request(32'h00000001, 32'h01000000, 32'h00400000, 32'h0);
   endtask

   task automatic test_random(int count);
      for (int i = 0; i < count; i++)
         send_request(rand_coeff(), rand_coeff(), rand_coeff(), rand_coeff());
   endtask

   task automatic test_back_to_back(int count);
      stall_enable = 0;
      test_random(count);
      stall_enable = 1;
   endtask

   initial begin
      error_count  = 0;
      stall_enable = 1;
      long_stalls  = 1;
      reset        = 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.coeff_zero  <= '0;
      req_ch.coeff_one   <= '0;
      req_ch.coeff_two   <= '0;
      req_ch.coeff_three <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      // hold until every response has come
      wait_drained();
      test_random(300);
      test_back_to_back(100);
      wait_drained();
      test_random(200);
      wait_drained();
      repeat (100) @(posedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule

// ===== files.f =====
rtl/sop_pkg.sv
rtl/sop_if.sv
rtl/sop_mod_cell.sv
rtl/sop_fold.sv
rtl/sop_rot_cell.sv
rtl/sop_post.sv
rtl/sine_of_polynomial_taylor.sv
dv/tb_sine_of_polynomial_taylor.sv
